### rtl/core/region_filtered_wrench_sensor_macros.svh
// ----------------------------------------------------------------------------
// Region-filtered wrench sensor assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef REGION_FILTERED_WRENCH_SENSOR_MACROS_SVH
`define REGION_FILTERED_WRENCH_SENSOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RFWS_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rfws check failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define RFWS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rfws check failed: next-cycle implication");

`endif

### rtl/core/rfws_pkg.sv
// ----------------------------------------------------------------------------
// rfws_pkg
// Types, constants and register codes of the region-filtered wrench sensor.
// ----------------------------------------------------------------------------
`default_nettype none

package rfws_pkg;

  localparam int WORD_W       = 32;
  localparam int FRAC_BITS    = 16;
  localparam int GUARD_BITS_D = 8;
  localparam int CHANNELS     = 6;
  localparam int WEIGHT_BITS  = 16;
  localparam int COUNT_W      = 16;
  localparam int ADDR_W       = 5;
  localparam int REG_IDX_W    = 3;

  localparam logic [WEIGHT_BITS-1:0] RETENTION_RESET = 16'd6554;

  localparam logic [REG_IDX_W-1:0] REG_BOX_MIN_X  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_BOX_MIN_Y  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_BOX_MIN_Z  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_BOX_MAX_X  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_BOX_MAX_Y  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_BOX_MAX_Z  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_RETENTION  = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_DYN_MODE   = 3'd7;

  typedef struct packed {
    logic signed [WORD_W-1:0]      box_min_x;
    logic signed [WORD_W-1:0]      box_min_y;
    logic signed [WORD_W-1:0]      box_min_z;
    logic signed [WORD_W-1:0]      box_max_x;
    logic signed [WORD_W-1:0]      box_max_y;
    logic signed [WORD_W-1:0]      box_max_z;
    logic        [WEIGHT_BITS-1:0] retention;
    logic                          dynamic_mode;
  } cfg_t;

endpackage

`default_nettype wire

### rtl/core/rfws_regs.sv
// ----------------------------------------------------------------------------
// rfws_regs
// APB-style configuration registers: box bounds, retention and mode.
// ----------------------------------------------------------------------------
`default_nettype none

module rfws_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rfws_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output rfws_pkg::cfg_t                cfg
);
  import rfws_pkg::*;

  logic [REG_IDX_W-1:0] idx;
  logic                 wr_en;

  assign idx    = paddr[ADDR_W-1:2];
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.box_min_x    <= '0;
      cfg.box_min_y    <= '0;
      cfg.box_min_z    <= '0;
      cfg.box_max_x    <= '0;
      cfg.box_max_y    <= '0;
      cfg.box_max_z    <= '0;
      cfg.retention    <= RETENTION_RESET;
      cfg.dynamic_mode <= 1'b1;
    end else if (wr_en) begin
      case (idx)
        REG_BOX_MIN_X: cfg.box_min_x    <= pwdata;
        REG_BOX_MIN_Y: cfg.box_min_y    <= pwdata;
        REG_BOX_MIN_Z: cfg.box_min_z    <= pwdata;
        REG_BOX_MAX_X: cfg.box_max_x    <= pwdata;
        REG_BOX_MAX_Y: cfg.box_max_y    <= pwdata;
        REG_BOX_MAX_Z: cfg.box_max_z    <= pwdata;
        REG_RETENTION: cfg.retention    <= pwdata[WEIGHT_BITS-1:0];
        REG_DYN_MODE:  cfg.dynamic_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_BOX_MIN_X: prdata = cfg.box_min_x;
      REG_BOX_MIN_Y: prdata = cfg.box_min_y;
      REG_BOX_MIN_Z: prdata = cfg.box_min_z;
      REG_BOX_MAX_X: prdata = cfg.box_max_x;
      REG_BOX_MAX_Y: prdata = cfg.box_max_y;
      REG_BOX_MAX_Z: prdata = cfg.box_max_z;
      REG_RETENTION: prdata = 32'(cfg.retention);
      REG_DYN_MODE:  prdata = 32'(cfg.dynamic_mode);
      default:       prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/rfws_accum.sv
// ----------------------------------------------------------------------------
// rfws_accum
// Input register, box test and saturating wrench accumulators.
// ----------------------------------------------------------------------------
`default_nettype none

module rfws_accum #(
  parameter int GUARD_BITS = rfws_pkg::GUARD_BITS_D,
  parameter int SUM_W      = rfws_pkg::WORD_W + GUARD_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  rfws_pkg::cfg_t                      cfg,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                contact_valid,
  input  logic                                tick_end,
  input  logic signed [rfws_pkg::WORD_W-1:0]  pos_in   [3],
  input  logic signed [rfws_pkg::WORD_W-1:0]  wrench_in [rfws_pkg::CHANNELS],
  output logic                                snap_valid,
  input  logic                                snap_ready,
  output logic signed [SUM_W-1:0]             snap_sums [rfws_pkg::CHANNELS],
  output logic [rfws_pkg::COUNT_W-1:0]        snap_count
);
  import rfws_pkg::*;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // Input register
  logic                     a_valid;
  logic                     a_contact;
  logic                     a_tick;
  logic signed [WORD_W-1:0] a_pos    [3];
  logic signed [WORD_W-1:0] a_wrench [CHANNELS];

  logic signed [SUM_W-1:0]  sums       [CHANNELS];
  logic signed [SUM_W-1:0]  sums_next  [CHANNELS];
  logic [COUNT_W-1:0]       count;
  logic [COUNT_W-1:0]       count_next;
  logic                     in_box;
  logic                     a_adv;
  logic signed [SUM_W:0]    raw [CHANNELS];

  assign in_box = a_contact &&
                  (cfg.box_min_x <= a_pos[0]) && (cfg.box_min_y <= a_pos[1]) &&
                  (cfg.box_min_z <= a_pos[2]) && (cfg.box_max_x >= a_pos[0]) &&
                  (cfg.box_max_y >= a_pos[1]) && (cfg.box_max_z >= a_pos[2]);

  // Non-tick items retire here; a tick item waits for the snapshot stage.
  assign a_adv      = a_valid && (!a_tick || snap_ready);
  assign in_ready   = !a_valid || a_adv;
  assign snap_valid = a_valid && a_tick;

  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      raw[i] = (SUM_W+1)'(sums[i]) + (SUM_W+1)'(a_wrench[i]);
      if (!in_box) begin
        sums_next[i] = sums[i];
      end else if (raw[i][SUM_W] != raw[i][SUM_W-1]) begin
        sums_next[i] = raw[i][SUM_W] ? SUM_MIN : SUM_MAX;
      end else begin
        sums_next[i] = raw[i][SUM_W-1:0];
      end
    end
    if (in_box && (count != {COUNT_W{1'b1}})) begin
      count_next = count + 1'b1;
    end else begin
      count_next = count;
    end
  end

  assign snap_sums  = sums_next;
  assign snap_count = count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      a_contact <= contact_valid;
      a_tick    <= tick_end;
      a_pos     <= pos_in;
      a_wrench  <= wrench_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        sums[i] <= '0;
      end
      count <= '0;
    end else if (a_adv) begin
      for (int i = 0; i < CHANNELS; i++) begin
        sums[i] <= a_tick ? '0 : sums_next[i];
      end
      count <= a_tick ? '0 : count_next;
    end
  end

endmodule

`default_nettype wire

### rtl/core/rfws_filter.sv
// ----------------------------------------------------------------------------
// rfws_filter
// Tick snapshot register and the reading update, which is also the output.
// ----------------------------------------------------------------------------
`default_nettype none

module rfws_filter #(
  parameter int GUARD_BITS = rfws_pkg::GUARD_BITS_D,
  parameter int SUM_W      = rfws_pkg::WORD_W + GUARD_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  rfws_pkg::cfg_t                      cfg,
  input  logic                                snap_valid,
  output logic                                snap_ready,
  input  logic signed [SUM_W-1:0]             snap_sums [rfws_pkg::CHANNELS],
  input  logic [rfws_pkg::COUNT_W-1:0]        snap_count,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [rfws_pkg::WORD_W-1:0]  readings [rfws_pkg::CHANNELS]
);
  import rfws_pkg::*;

  localparam int PROD_W = SUM_W + WEIGHT_BITS + 2;
  localparam int ACC_W  = PROD_W + 1;
  localparam int CS_W   = 48;
  localparam logic signed [ACC_W-1:0] RD_MAX = ACC_W'(2147483647);
  localparam logic signed [ACC_W-1:0] RD_MIN = ~RD_MAX;
  localparam logic signed [ACC_W-1:0] HALF   = ACC_W'(1) <<< (WEIGHT_BITS - 1);

  logic                     b_valid;
  logic signed [SUM_W-1:0]  b_sums [CHANNELS];
  logic [COUNT_W-1:0]       b_count;
  logic                     out_free;
  logic                     b_adv;

  logic signed [WEIGHT_BITS+1:0] w_new;
  logic signed [WEIGHT_BITS+1:0] w_old;
  logic signed [PROD_W-1:0]      p_new [CHANNELS];
  logic signed [PROD_W-1:0]      p_old [CHANNELS];
  logic signed [ACC_W-1:0]       acc   [CHANNELS];
  logic signed [ACC_W-1:0]       shr   [CHANNELS];
  logic signed [WORD_W-1:0]      readings_next [CHANNELS];
  logic [CS_W-1:0]               cnt_shift;
  logic signed [WORD_W-1:0]      cnt_reading;

  assign out_free   = !out_valid || out_ready;
  assign b_adv      = b_valid && out_free;
  assign snap_ready = !b_valid || out_free;

  assign w_new = $signed({2'b00, cfg.retention});
  assign w_old = $signed((WEIGHT_BITS+2)'(1) << WEIGHT_BITS) - w_new;

  assign cnt_shift   = CS_W'(b_count) << FRAC_BITS;
  assign cnt_reading = (|cnt_shift[CS_W-1:WORD_W-1]) ? $signed(32'h7fff_ffff)
                                                     : $signed(cnt_shift[WORD_W-1:0]);

  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      p_new[i] = PROD_W'(b_sums[i]) * PROD_W'(w_new);
      p_old[i] = PROD_W'(readings[i]) * PROD_W'(w_old);
      // Round to nearest with halves toward plus infinity, then floor.
      acc[i] = ACC_W'(p_new[i]) + ACC_W'(p_old[i]) + HALF;
      shr[i] = acc[i] >>> WEIGHT_BITS;
      if (!cfg.dynamic_mode) begin
        readings_next[i] = (i == 2) ? cnt_reading : readings[i];
      end else if (shr[i] > RD_MAX) begin
        readings_next[i] = RD_MAX[WORD_W-1:0];
      end else if (shr[i] < RD_MIN) begin
        readings_next[i] = RD_MIN[WORD_W-1:0];
      end else begin
        readings_next[i] = shr[i][WORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (snap_ready) begin
      b_valid <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_ready) begin
      b_sums  <= snap_sums;
      b_count <= snap_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        readings[i] <= '0;
      end
    end else if (b_adv) begin
      out_valid <= 1'b1;
      readings  <= readings_next;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

### rtl/core/region_filtered_wrench_sensor.sv
// ----------------------------------------------------------------------------
// region_filtered_wrench_sensor
// Box-filtered contact wrench accumulation with a per-tick moving average or in-box count.
// ----------------------------------------------------------------------------
// The block takes one contact per clock cycle while in_ready is high. Contacts
// inside the configured box add their wrench to six saturating accumulators
// in the cycle after they are taken. The last contact of a tick moves a
// snapshot of the sums into a second register, from which the six updated
// readings are written into the output register. A result that is not taken
// holds only tick items behind it: the snapshot register and the output
// register each hold one tick, and contacts keep flowing until a third tick
// item arrives. Each of the six filter lanes, between the snapshot and output
// registers, is one 40 by 18 and one 32 by 18 multiply with a rounding add.
`default_nettype none

module region_filtered_wrench_sensor #(
  parameter int GUARD_BITS = rfws_pkg::GUARD_BITS_D
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rfws_pkg::ADDR_W-1:0]         paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                contact_valid,
  input  logic                                tick_end,
  input  logic signed [rfws_pkg::WORD_W-1:0]  pos_x,
  input  logic signed [rfws_pkg::WORD_W-1:0]  pos_y,
  input  logic signed [rfws_pkg::WORD_W-1:0]  pos_z,
  input  logic signed [rfws_pkg::WORD_W-1:0]  force_x,
  input  logic signed [rfws_pkg::WORD_W-1:0]  force_y,
  input  logic signed [rfws_pkg::WORD_W-1:0]  force_z,
  input  logic signed [rfws_pkg::WORD_W-1:0]  torque_x,
  input  logic signed [rfws_pkg::WORD_W-1:0]  torque_y,
  input  logic signed [rfws_pkg::WORD_W-1:0]  torque_z,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [rfws_pkg::WORD_W-1:0]  reading_fx,
  output logic signed [rfws_pkg::WORD_W-1:0]  reading_fy,
  output logic signed [rfws_pkg::WORD_W-1:0]  reading_fz,
  output logic signed [rfws_pkg::WORD_W-1:0]  reading_tx,
  output logic signed [rfws_pkg::WORD_W-1:0]  reading_ty,
  output logic signed [rfws_pkg::WORD_W-1:0]  reading_tz
);
  import rfws_pkg::*;

  `include "region_filtered_wrench_sensor_macros.svh"

  localparam int SUM_W = WORD_W + GUARD_BITS;

  cfg_t                     cfg;
  logic signed [WORD_W-1:0] pos_in    [3];
  logic signed [WORD_W-1:0] wrench_in [CHANNELS];
  logic                     snap_valid;
  logic                     snap_ready;
  logic signed [SUM_W-1:0]  snap_sums [CHANNELS];
  logic [COUNT_W-1:0]       snap_count;
  logic signed [WORD_W-1:0] readings  [CHANNELS];

  assign pos_in[0]    = pos_x;
  assign pos_in[1]    = pos_y;
  assign pos_in[2]    = pos_z;
  assign wrench_in[0] = force_x;
  assign wrench_in[1] = force_y;
  assign wrench_in[2] = force_z;
  assign wrench_in[3] = torque_x;
  assign wrench_in[4] = torque_y;
  assign wrench_in[5] = torque_z;

  assign reading_fx = readings[0];
  assign reading_fy = readings[1];
  assign reading_fz = readings[2];
  assign reading_tx = readings[3];
  assign reading_ty = readings[4];
  assign reading_tz = readings[5];

  rfws_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rfws_accum #(
    .GUARD_BITS (GUARD_BITS),
    .SUM_W      (SUM_W)
  ) u_accum (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .contact_valid (contact_valid),
    .tick_end      (tick_end),
    .pos_in        (pos_in),
    .wrench_in     (wrench_in),
    .snap_valid    (snap_valid),
    .snap_ready    (snap_ready),
    .snap_sums     (snap_sums),
    .snap_count    (snap_count)
  );

  rfws_filter #(
    .GUARD_BITS (GUARD_BITS),
    .SUM_W      (SUM_W)
  ) u_filter (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap_sums  (snap_sums),
    .snap_count (snap_count),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .readings   (readings)
  );

  // A free output register always leaves room for the next tick snapshot.
  `RFWS_ASSERT_SAME(a_snap_room, clk, rst, !out_valid, snap_ready)
  // A contact that closes no tick never holds up the following item.
  `RFWS_ASSERT_NEXT(a_contact_flow, clk, rst, in_valid && in_ready && !tick_end, in_ready)
  // A snapshot cannot overtake a waiting result.
  `RFWS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)

endmodule

`default_nettype wire

### dv/region_filtered_wrench_sensor_tb.sv
// ----------------------------------------------------------------------------
// region_filtered_wrench_sensor_tb
// Drives contacts over the valid/ready input, programs the sensing box and
// the filter over APB, and checks each reading set field by field against
// an in-line model of the box test, the saturating sums and the filter.
// ----------------------------------------------------------------------------
module region_filtered_wrench_sensor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rfws_pkg::*;

  localparam int     SUM_W         = WORD_W + GUARD_BITS_D;
  localparam longint SUM_TOP       = (longint'(1) <<< (SUM_W - 1)) - 1;
  localparam longint WEIGHT_ONE    = longint'(1) <<< WEIGHT_BITS;
  localparam int     CH_FZ         = 2;
  localparam int     SETTLE_CYCLES = 8;
  localparam int     QUIET_LIMIT   = 3000;
  localparam int     MAX_REPORTS   = 60;
  localparam int     PHASE_ITEMS   = 150;

  localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fffffff;
  localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh80000000;

  typedef struct packed {
    logic                     contact_valid;
    logic                     tick_end;
    logic signed [WORD_W-1:0] pos_x;
    logic signed [WORD_W-1:0] pos_y;
    logic signed [WORD_W-1:0] pos_z;
    logic signed [WORD_W-1:0] force_x;
    logic signed [WORD_W-1:0] force_y;
    logic signed [WORD_W-1:0] force_z;
    logic signed [WORD_W-1:0] torque_x;
    logic signed [WORD_W-1:0] torque_y;
    logic signed [WORD_W-1:0] torque_z;
  } contact_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] fx;
    logic signed [WORD_W-1:0] fy;
    logic signed [WORD_W-1:0] fz;
    logic signed [WORD_W-1:0] tx;
    logic signed [WORD_W-1:0] ty;
    logic signed [WORD_W-1:0] tz;
  } reading_set_t;

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic in_valid, in_ready, out_valid, out_ready;
  logic contact_valid, tick_end;
  logic signed [WORD_W-1:0] pos_x, pos_y, pos_z;
  logic signed [WORD_W-1:0] force_x, force_y, force_z;
  logic signed [WORD_W-1:0] torque_x, torque_y, torque_z;
  logic signed [WORD_W-1:0] reading_fx, reading_fy, reading_fz;
  logic signed [WORD_W-1:0] reading_tx, reading_ty, reading_tz;

  // Model state: configuration, sums, readings and the in-box tally.
  cfg_t                     sensor_cfg;
  logic signed [SUM_W-1:0]  wrench_acc [CHANNELS];
  logic signed [WORD_W-1:0] filtered [CHANNELS];
  logic [COUNT_W-1:0]       inbox_tally;
  reading_set_t             readings_due [$];

  int error_count;
  int quiet_cycles;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_off_cycles;

  string channel_name [CHANNELS] = '{"fx", "fy", "fz", "tx", "ty", "tz"};

  region_filtered_wrench_sensor dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .contact_valid(contact_valid), .tick_end(tick_end),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .force_x(force_x), .force_y(force_y), .force_z(force_z),
    .torque_x(torque_x), .torque_y(torque_y), .torque_z(torque_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .reading_fx(reading_fx), .reading_fy(reading_fy), .reading_fz(reading_fz),
    .reading_tx(reading_tx), .reading_ty(reading_ty), .reading_tz(reading_tz)
  );

  always #6 clk = ~clk;

  task automatic report_mismatch(string what);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
  endtask

  function automatic logic signed [WORD_W-1:0] clamp_word(longint v);
    if (v > longint'(WORD_MAX)) return WORD_MAX;
    if (v < longint'(WORD_MIN)) return WORD_MIN;
    return WORD_W'(v);
  endfunction

  function automatic logic signed [SUM_W-1:0] clamp_sum(longint v);
    if (v > SUM_TOP) return SUM_W'(SUM_TOP);
    if (v < -SUM_TOP - 1) return SUM_W'(-SUM_TOP - 1);
    return SUM_W'(v);
  endfunction

  function automatic bit contact_in_box(contact_t c);
    return $signed(sensor_cfg.box_min_x) <= $signed(c.pos_x) &&
           $signed(sensor_cfg.box_min_y) <= $signed(c.pos_y) &&
           $signed(sensor_cfg.box_min_z) <= $signed(c.pos_z) &&
           $signed(sensor_cfg.box_max_x) >= $signed(c.pos_x) &&
           $signed(sensor_cfg.box_max_y) >= $signed(c.pos_y) &&
           $signed(sensor_cfg.box_max_z) >= $signed(c.pos_z);
  endfunction

  // Applies one accepted contact; a tick end queues the reading set it yields.
  task automatic fold_contact(contact_t c);
    logic signed [WORD_W-1:0] wrench [CHANNELS];
    longint blend;
    wrench = '{c.force_x, c.force_y, c.force_z, c.torque_x, c.torque_y, c.torque_z};
    if (c.contact_valid && contact_in_box(c)) begin
      for (int i = 0; i < CHANNELS; i++)
        wrench_acc[i] = clamp_sum(longint'(wrench_acc[i]) + longint'(wrench[i]));
      if (inbox_tally != '1) inbox_tally++;
    end
    if (c.tick_end) begin
      if (sensor_cfg.dynamic_mode) begin
        for (int i = 0; i < CHANNELS; i++) begin
          blend = longint'(wrench_acc[i]) * longint'(sensor_cfg.retention) +
                  longint'(filtered[i]) * (WEIGHT_ONE - longint'(sensor_cfg.retention)) +
                  (longint'(1) <<< (FRAC_BITS - 1));
          // Arithmetic shift of the rounded sum floors toward minus infinity.
          filtered[i] = clamp_word(blend >>> FRAC_BITS);
        end
      end else begin
        filtered[CH_FZ] = clamp_word(longint'(inbox_tally) <<< FRAC_BITS);
      end
      readings_due.push_back({filtered[0], filtered[1], filtered[2],
                              filtered[3], filtered[4], filtered[5]});
      for (int i = 0; i < CHANNELS; i++) wrench_acc[i] = '0;
      inbox_tally = '0;
    end
  endtask

  task automatic set_idling(int sender_pct, int receiver_pct);
    send_idle_pct  = sender_pct;
    recv_stall_pct = receiver_pct;
  endtask

  // Lowers valid, waits for every pending reading set, then lets any contact
  // still in the pipeline land in the sums.
  task automatic wait_for_idle();
    in_valid <= 1'b0;
    while (readings_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic send_contact(contact_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    contact_valid <= c.contact_valid;
    tick_end      <= c.tick_end;
    pos_x         <= c.pos_x;
    pos_y         <= c.pos_y;
    pos_z         <= c.pos_z;
    force_x       <= c.force_x;
    force_y       <= c.force_y;
    force_z       <= c.force_z;
    torque_x      <= c.torque_x;
    torque_y      <= c.torque_y;
    torque_z      <= c.torque_z;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    fold_contact(c);
    @(negedge clk);
  endtask

  // Writes one register once the block is idle, then reads it back.
  task automatic program_register(logic [REG_IDX_W-1:0] idx, logic [31:0] value);
    logic [31:0] want;
    logic [31:0] readback;
    wait_for_idle();
    want = value;
    case (idx)
      REG_BOX_MIN_X: sensor_cfg.box_min_x = value;
      REG_BOX_MIN_Y: sensor_cfg.box_min_y = value;
      REG_BOX_MIN_Z: sensor_cfg.box_min_z = value;
      REG_BOX_MAX_X: sensor_cfg.box_max_x = value;
      REG_BOX_MAX_Y: sensor_cfg.box_max_y = value;
      REG_BOX_MAX_Z: sensor_cfg.box_max_z = value;
      REG_RETENTION: begin
        sensor_cfg.retention = value[WEIGHT_BITS-1:0];
        want = 32'(value[WEIGHT_BITS-1:0]);
      end
      REG_DYN_MODE: begin
        sensor_cfg.dynamic_mode = value[0];
        want = 32'(value[0]);
      end
      default: ;
    endcase
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    pwrite  <= 1'b1;
    psel    <= 1'b1;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    readback = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    if (readback !== want)
      report_mismatch($sformatf("register %0d read 0x%08h, expected 0x%08h",
                                idx, readback, want));
  endtask

  task automatic program_box(logic signed [WORD_W-1:0] lo_x, lo_y, lo_z,
                             logic signed [WORD_W-1:0] hi_x, hi_y, hi_z);
    program_register(REG_BOX_MIN_X, lo_x);
    program_register(REG_BOX_MIN_Y, lo_y);
    program_register(REG_BOX_MIN_Z, lo_z);
    program_register(REG_BOX_MAX_X, hi_x);
    program_register(REG_BOX_MAX_Y, hi_y);
    program_register(REG_BOX_MAX_Z, hi_z);
  endtask

  task automatic program_filter(logic [WEIGHT_BITS-1:0] weight, bit dynamic_on);
    program_register(REG_RETENTION, 32'(weight));
    program_register(REG_DYN_MODE, 32'(dynamic_on));
  endtask

  function automatic contact_t make_contact(bit valid, bit tick,
                                            logic signed [WORD_W-1:0] x, y, z,
                                            logic signed [WORD_W-1:0] f, t);
    contact_t c;
    c.contact_valid = valid;
    c.tick_end      = tick;
    c.pos_x         = x;
    c.pos_y         = y;
    c.pos_z         = z;
    c.force_x       = f;
    c.force_y       = f;
    c.force_z       = f;
    c.torque_x      = t;
    c.torque_y      = t;
    c.torque_z      = t;
    return c;
  endfunction

  // Aimed coordinates land inside [lo, hi] or on a bound; the rest are wild.
  function automatic logic signed [WORD_W-1:0] pick_coord(bit aim,
                                                          logic signed [WORD_W-1:0] lo, hi);
    longint span;
    int roll;
    roll = $urandom_range(9);
    if (aim && lo <= hi) begin
      if (roll == 0) return lo;
      if (roll == 1) return hi;
      span = longint'(hi) - longint'(lo);
      return WORD_W'(longint'(lo) + longint'($urandom_range(32'(span))));
    end
    if (roll == 0) return lo - 1;
    if (roll < 3) return hi + 1;
    return $urandom();
  endfunction

  function automatic logic signed [WORD_W-1:0] pick_wrench();
    int roll;
    roll = $urandom_range(9);
    if (roll == 0) return WORD_MAX;
    if (roll == 1) return WORD_MIN;
    if (roll < 5) return $urandom();
    return WORD_W'(longint'($urandom_range(1 << 21)) - (longint'(1) << 20));
  endfunction

  function automatic contact_t random_contact(int tick_pct);
    contact_t c;
    bit aim;
    aim = $urandom_range(99) < 75;
    c.contact_valid = $urandom_range(99) < 90;
    c.tick_end      = $urandom_range(99) < tick_pct;
    c.pos_x         = pick_coord(aim, sensor_cfg.box_min_x, sensor_cfg.box_max_x);
    c.pos_y         = pick_coord(aim, sensor_cfg.box_min_y, sensor_cfg.box_max_y);
    c.pos_z         = pick_coord(aim, sensor_cfg.box_min_z, sensor_cfg.box_max_z);
    c.force_x       = pick_wrench();
    c.force_y       = pick_wrench();
    c.force_z       = pick_wrench();
    c.torque_x      = pick_wrench();
    c.torque_y      = pick_wrench();
    c.torque_z      = pick_wrench();
    return c;
  endfunction

  // With the reset box only the origin itself is inside.
  task automatic test_reset_defaults();
    set_idling(0, 0);
    send_contact(make_contact(1, 0, 0, 0, 0, 32'sd65536, -32'sd32768));
    send_contact(make_contact(1, 0, 1, 0, 0, 32'sd123456, 32'sd7));
    send_contact(make_contact(1, 0, 0, 0, -1, 32'sd99999, -32'sd5));
    send_contact(make_contact(0, 0, 0, 0, 0, WORD_MAX, WORD_MAX));
    // A contact that also closes the tick is summed before the update.
    send_contact(make_contact(1, 1, 0, 0, 0, 32'sd300000, -32'sd300000));
    send_contact(make_contact(0, 1, 0, 0, 0, 0, 0));
    send_contact(make_contact(1, 1, 0, 0, 0, WORD_MAX, WORD_MIN));
    send_contact(make_contact(1, 0, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX));
    send_contact(make_contact(1, 1, WORD_MIN, 0, 0, WORD_MAX, WORD_MAX));
    send_contact(make_contact(0, 1, -1, -1, -1, -1, -1));
    wait_for_idle();
  endtask

  task automatic test_box_bounds();
    logic signed [WORD_W-1:0] lo [3];
    logic signed [WORD_W-1:0] hi [3];
    logic signed [WORD_W-1:0] spot [3];
    contact_t c;
    program_box(-32'sd3, -32'sd100, 32'sd7, 32'sd4, 32'sd20, 32'sd7);
    program_filter(16'd32768, 1'b1);
    set_idling(14, 14);
    lo = '{sensor_cfg.box_min_x, sensor_cfg.box_min_y, sensor_cfg.box_min_z};
    hi = '{sensor_cfg.box_max_x, sensor_cfg.box_max_y, sensor_cfg.box_max_z};
    for (int axis = 0; axis < 3; axis++) begin
      for (int k = 0; k < 4; k++) begin
        spot = lo;
        case (k)
          0: spot[axis] = lo[axis];
          1: spot[axis] = lo[axis] - 1;
          2: spot[axis] = hi[axis];
          default: spot[axis] = hi[axis] + 1;
        endcase
        c = random_contact(0);
        c.contact_valid = 1'b1;
        c.tick_end = (k == 3);
        c.pos_x = spot[0];
        c.pos_y = spot[1];
        c.pos_z = spot[2];
        send_contact(c);
      end
    end
    // Lower x bound above the upper one: the box is empty.
    program_register(REG_BOX_MIN_X, 32'sd10);
    send_contact(make_contact(1, 0, 32'sd4, 32'sd0, 32'sd7, 32'sd70000, 32'sd1));
    send_contact(make_contact(1, 0, 32'sd7, 32'sd0, 32'sd7, 32'sd70000, 32'sd1));
    send_contact(make_contact(1, 1, 32'sd10, 32'sd0, 32'sd7, 32'sd70000, 32'sd1));
    wait_for_idle();
  endtask

  // A weight of one lets the saturated sums show through in the readings.
  task automatic test_sum_saturation();
    program_box(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MAX, WORD_MAX, WORD_MAX);
    program_filter(16'd1, 1'b1);
    set_idling(0, 0);
    repeat (260) send_contact(make_contact(1, 0, 0, 0, 0, WORD_MAX, WORD_MIN));
    send_contact(make_contact(1, 1, 0, 0, 0, WORD_MIN, WORD_MAX));
    repeat (260) send_contact(make_contact(1, 0, 0, 0, 0, WORD_MIN, WORD_MAX));
    send_contact(make_contact(1, 1, 0, 0, 0, WORD_MAX, WORD_MIN));
    program_filter(16'hFFFF, 1'b1);
    repeat (3) send_contact(make_contact(1, 0, 0, 0, 0, WORD_MAX, WORD_MIN));
    send_contact(make_contact(0, 1, 0, 0, 0, 0, 0));
    wait_for_idle();
  endtask

  task automatic test_count_saturation();
    program_box(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MAX, WORD_MAX, WORD_MAX);
    program_filter(RETENTION_RESET, 1'b0);
    set_idling(0, 0);
    repeat (3) send_contact(make_contact(1, 0, 0, 0, 0, 32'sd5, -32'sd5));
    send_contact(make_contact(0, 1, 0, 0, 0, 0, 0));
    send_contact(make_contact(0, 1, 0, 0, 0, 0, 0));
    // Contacts away from the origin count too, since the box spans everything.
    repeat (40) send_contact(make_contact(1, 0, 32'sd9, -32'sd9, 0, 32'sd1, -32'sd1));
    send_contact(make_contact(1, 1, 0, 0, 0, 32'sd1, -32'sd1));
    wait_for_idle();
  endtask

  // The mode at the tick end decides the update; sums gather in both modes.
  task automatic test_mode_switch_mid_tick();
    contact_t c;
    program_box(-32'sd65536, -32'sd65536, -32'sd65536, 32'sd65536, 32'sd65536, 32'sd65536);
    program_filter(16'd20000, 1'b1);
    set_idling(0, 0);
    repeat (5) begin
      c = random_contact(0);
      c.contact_valid = 1'b1;
      send_contact(c);
    end
    program_filter(16'd20000, 1'b0);
    send_contact(make_contact(0, 1, 0, 0, 0, 0, 0));
    repeat (4) begin
      c = random_contact(0);
      c.contact_valid = 1'b1;
      send_contact(c);
    end
    program_filter(16'd40000, 1'b1);
    send_contact(make_contact(1, 1, 0, 0, 0, 32'sd65536, -32'sd65536));
    wait_for_idle();
  endtask

  // The receiver holds off while ticks keep coming, so the block fills and
  // stops taking contacts until the stall ends.
  task automatic test_receiver_hold_off();
    contact_t c;
    program_box(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MAX, WORD_MAX, WORD_MAX);
    program_filter(16'd30000, 1'b1);
    set_idling(0, 0);
    hold_off_cycles = 300;
    for (int k = 0; k < 40; k++) begin
      c = random_contact(0);
      c.tick_end = (k % 3 == 2);
      send_contact(c);
    end
    wait_for_idle();
  endtask

  task automatic configure_random_phase(int phase);
    logic signed [WORD_W-1:0] lo [3];
    logic signed [WORD_W-1:0] hi [3];
    logic [WEIGHT_BITS-1:0] weight;
    longint center, half;
    for (int a = 0; a < 3; a++) begin
      case (phase % 4)
        0: begin
          center = longint'($signed($urandom()));
          half   = longint'($urandom_range(1 << 24));
          lo[a]  = clamp_word(center - half);
          hi[a]  = clamp_word(center + half);
        end
        1: begin
          lo[a] = WORD_MIN;
          hi[a] = WORD_MAX;
        end
        2: begin
          lo[a] = $urandom();
          hi[a] = $urandom();
        end
        default: begin
          lo[a] = $urandom();
          hi[a] = lo[a] + $urandom_range(3);
        end
      endcase
    end
    if (phase == 0) weight = 16'hFFFF;
    else if (phase == 1) weight = '0;
    else weight = $urandom_range(65535);
    program_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
    program_filter(weight, !(phase == 3 || phase == 5));
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 8; phase++) begin
      configure_random_phase(phase);
      case (phase % 4)
        0: set_idling(0, 0);
        1: set_idling(60, 0);
        2: set_idling(0, 60);
        default: set_idling(14, 14);
      endcase
      repeat (PHASE_ITEMS) send_contact(random_contact(15));
    end
    wait_for_idle();
  endtask

  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      out_ready <= 1'b0;
      hold_off_cycles = hold_off_cycles - 1;
    end else begin
      out_ready <= $urandom_range(99) >= recv_stall_pct;
    end
  end

  always @(posedge clk) begin : check_readings
    reading_set_t got;
    reading_set_t want;
    if (!rst && out_valid && out_ready) begin
      got = {reading_fx, reading_fy, reading_fz, reading_tx, reading_ty, reading_tz};
      if (readings_due.size() == 0) begin
        report_mismatch($sformatf("reading set with none expected: %h", got));
      end else begin
        want = readings_due.pop_front();
        for (int i = 0; i < CHANNELS; i++) begin
          if (got[(CHANNELS-1-i)*WORD_W +: WORD_W] !== want[(CHANNELS-1-i)*WORD_W +: WORD_W])
            report_mismatch($sformatf("reading_%s got 0x%08h, expected 0x%08h",
                                      channel_name[i],
                                      got[(CHANNELS-1-i)*WORD_W +: WORD_W],
                                      want[(CHANNELS-1-i)*WORD_W +: WORD_W]));
        end
      end
    end
  end

  // Counts cycles in which no transfer of any kind takes place.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
      quiet_cycles = 0;
    else
      quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("region_filtered_wrench_sensor_tb: errors");
      $finish;
    end
  end

  initial begin
    rst             = 1'b1;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_valid        = 1'b0;
    out_ready       = 1'b0;
    contact_valid   = 1'b0;
    tick_end        = 1'b0;
    pos_x           = '0;
    pos_y           = '0;
    pos_z           = '0;
    force_x         = '0;
    force_y         = '0;
    force_z         = '0;
    torque_x        = '0;
    torque_y        = '0;
    torque_z        = '0;
    error_count     = 0;
    quiet_cycles    = 0;
    hold_off_cycles = 0;
    set_idling(0, 0);
    sensor_cfg              = '0;
    sensor_cfg.retention    = RETENTION_RESET;
    sensor_cfg.dynamic_mode = 1'b1;
    for (int i = 0; i < CHANNELS; i++) begin
      wrench_acc[i] = '0;
      filtered[i]   = '0;
    end
    inbox_tally = '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_box_bounds();
    test_sum_saturation();
    test_count_saturation();
    test_mode_switch_mid_tick();
    test_receiver_hold_off();
    test_random_traffic();

    wait_for_idle();
    repeat (4 * SETTLE_CYCLES) @(negedge clk);
    if (readings_due.size() != 0)
      report_mismatch($sformatf("%0d reading sets never arrived", readings_due.size()));
    if (error_count == 0)
      $display("region_filtered_wrench_sensor_tb: clean");
    else
      $display("region_filtered_wrench_sensor_tb: errors");
    $finish;
  end

endmodule
